@@ design/acb_pkg.sv @@
`timescale 1ns / 1ps
package acb_pkg;
  localparam int CHANNELS = 8;
  localparam int CH_W = 3;
  localparam logic [7:0] FOREVER_CODE = 8'd255;
  localparam logic signed [16:0] DEFAULT_END = 17'sd100;
  localparam logic [9:0] MIN_PERIOD_RESET = 10'd10;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_CREATE = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_STOP = 3'd3;
  localparam logic [2:0] OP_DESTROY = 3'd4;
  localparam logic [2:0] OP_QUERY = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_CMD, S_TLOAD, S_TMUL, S_TDIV, S_TFIN, S_TEMPTY
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [33:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [33:0] quotient;
  } div_rsp_t;
endpackage

@@ design/acb_divider.sv @@
`timescale 1ns / 1ps
module acb_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  acb_pkg::div_req_t req,
  output acb_pkg::div_rsp_t rsp
);
  logic [33:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [15:0] dsr_r, dsr_nxt;
  logic neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [34:0] trial;
  logic [33:0] mag;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dsr_nxt = dsr_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    trial = '0;
    mag = req.dividend[33] ? 34'(-req.dividend) : 34'(req.dividend);
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = mag;
      dsr_nxt = req.divisor;
      neg_nxt = req.dividend[33];
      busy_nxt = 1'b1;
      cnt_nxt = 6'd34;
    end else if (busy_r) begin
      trial = {rem_r, quo_r[33]} - {19'd0, dsr_r};
      if (!trial[34]) begin
        rem_nxt = trial[33:0];
        quo_nxt = {quo_r[32:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[32:0], quo_r[33]};
        quo_nxt = {quo_r[32:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);
endmodule

@@ design/animation_channel_bank.sv @@
`timescale 1ns / 1ps
// Bank of eight animation channels driven by command transactions.
// Input: start with in_opcode, in_channel and create/tick operands; a
// transaction is taken when start is high and busy is low.
// Results: each one is shown for one cycle with out_valid high; out_last
// marks the final result of a transaction. Results cannot be stalled.
// Create, start, stop, destroy, query and unknown opcodes give one result,
// registered from the command state. A tick visits every channel in turn;
// a running channel past its delay needs a multiply state and a 34-step
// shared restoring divider, while any other channel goes straight from its
// load state to its finish state. A closing state follows the last channel,
// and the last result of a tick is registered from that closing state.
// busy is high from acceptance until the cycle in which the last result
// is shown. The next transaction may be accepted in that cycle.
// Configuration: cfg_valid/cfg_ready write min_period; ready is high
// while idle. A min_period of zero acts as one.
// Reset (synchronous, rst_n low) frees every channel and sets min_period
// to ten. Per-channel parameters are written by create.
module animation_channel_bank (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_opcode,
  input  logic [2:0]         in_channel,
  input  logic [15:0]        in_elapsed_ticks,
  input  logic [15:0]        in_delay_ticks,
  input  logic [15:0]        in_period_ticks,
  input  logic [7:0]         in_repeat_count,
  input  logic               in_ping_pong,
  input  logic signed [15:0] in_start_value,
  input  logic signed [15:0] in_end_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [9:0]         cfg_min_period,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [2:0]         out_channel_out,
  output logic signed [16:0] out_current_value,
  output logic               out_started,
  output logic               out_value_changed,
  output logic               out_reloaded,
  output logic               out_finished,
  output logic               out_is_running,
  output logic               out_last
);
  localparam int N = acb_pkg::CHANNELS;

  acb_pkg::state_t state_r, state_nxt;
  logic [9:0] minp_r;
  logic [N-1:0] used_r, used_nxt, run_r, run_nxt, fp_r, fp_nxt;
  logic signed [17:0] pos_r [N];
  logic [15:0] dly_r [N];
  logic [15:0] per_r [N];
  logic [7:0] rep_r [N];
  logic swp_r [N];
  logic signed [16:0] from_r [N];
  logic signed [16:0] to_r [N];
  logic signed [16:0] val_r [N];

  logic [2:0] op_r;
  logic [2:0] ch_r, ch_nxt;
  logic [15:0] el_r, dl_r, pd_r;
  logic [7:0] rc_r;
  logic pp_r;
  logic signed [15:0] sv_r, ev_r;
  logic [3:0] nres_r, nres_nxt;
  logic st_r, st_nxt;
  logic signed [17:0] cpos_r, cpos_nxt;
  logic signed [17:0] dlt;
  logic signed [35:0] mulw;

  acb_pkg::div_req_t dreq;
  acb_pkg::div_rsp_t drsp;
  acb_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // pending write-back of one channel
  logic wr_pos, wr_val, wr_rel, wr_new;
  logic signed [17:0] pos_w;
  logic signed [16:0] val_w;
  logic [7:0] rep_w;

  // result register
  logic ov_nxt, ol_nxt, ost_nxt, ovc_nxt, orl_nxt, ofn_nxt, orun_nxt;
  logic [1:0] ostat_nxt;
  logic [2:0] och_nxt;
  logic signed [16:0] ocv_nxt;

  logic [15:0] mp;
  logic [2:0] free_idx;
  logic free_any;
  logic signed [17:0] padd;
  logic signed [16:0] v, fs, ts, nf, nt;
  logic again;
  logic [7:0] rdec;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = 3'(i);
      end
    end
  end

  assign mp = (minp_r == 10'd0) ? 16'd1 : {6'd0, minp_r};

  assign dlt = 18'(to_r[ch_r]) - 18'(from_r[ch_r]);
  assign mulw = $signed({1'b0, cpos_r[16:0]}) * dlt;

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    run_nxt = run_r;
    fp_nxt = fp_r;
    ch_nxt = ch_r;
    nres_nxt = nres_r;
    st_nxt = st_r;
    cpos_nxt = cpos_r;
    dreq = '0;
    wr_pos = 1'b0; wr_val = 1'b0; wr_rel = 1'b0; wr_new = 1'b0;
    pos_w = '0; val_w = '0; rep_w = rep_r[ch_r];
    ov_nxt = 1'b0; ol_nxt = 1'b0; ost_nxt = 1'b0; ovc_nxt = 1'b0;
    orl_nxt = 1'b0; ofn_nxt = 1'b0; orun_nxt = 1'b0;
    ostat_nxt = acb_pkg::ST_OK; och_nxt = '0; ocv_nxt = '0;
    padd = pos_r[ch_r] + $signed({2'b00, el_r});
    v = '0; again = 1'b0; rdec = rep_r[ch_r];
    fs = from_r[ch_r]; ts = to_r[ch_r]; nf = fs; nt = ts;
    unique case (state_r)
      acb_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (in_opcode == acb_pkg::OP_TICK) ? acb_pkg::S_TLOAD : acb_pkg::S_CMD;
          ch_nxt = (in_opcode == acb_pkg::OP_TICK) ? 3'd0 : in_channel;
          nres_nxt = '0;
        end
      end
      acb_pkg::S_CMD: begin
        state_nxt = acb_pkg::S_IDLE;
        ov_nxt = 1'b1;
        ol_nxt = 1'b1;
        unique case (op_r)
          acb_pkg::OP_CREATE: begin
            if (free_any) begin
              used_nxt[free_idx] = 1'b1;
              run_nxt[free_idx] = 1'b0;
              fp_nxt[free_idx] = 1'b1;
              wr_new = 1'b1;
              och_nxt = free_idx;
              nf = 17'(sv_r); nt = 17'(ev_r);
              if (sv_r == ev_r) begin
                nf = '0; nt = acb_pkg::DEFAULT_END;
              end
              ocv_nxt = (nf < nt) ? nf - 17'sd1 : ((nf > nt) ? nf + 17'sd1 : 17'sd0);
            end else begin
              ostat_nxt = acb_pkg::ST_FULL;
            end
          end
          acb_pkg::OP_START, acb_pkg::OP_STOP, acb_pkg::OP_DESTROY,
          acb_pkg::OP_QUERY: begin
            och_nxt = ch_r;
            if (!used_r[ch_r]) begin
              ostat_nxt = acb_pkg::ST_UNUSED;
            end else begin
              if (op_r == acb_pkg::OP_START) begin
                run_nxt[ch_r] = 1'b1; fp_nxt[ch_r] = 1'b1;
              end
              if (op_r == acb_pkg::OP_STOP) run_nxt[ch_r] = 1'b0;
              if (op_r == acb_pkg::OP_DESTROY) begin
                used_nxt[ch_r] = 1'b0; run_nxt[ch_r] = 1'b0; fp_nxt[ch_r] = 1'b0;
              end else begin
                ocv_nxt = val_r[ch_r];
                orun_nxt = run_nxt[ch_r];
              end
            end
          end
          default: ;
        endcase
      end
      acb_pkg::S_TLOAD: begin
        st_nxt = 1'b0;
        if (used_r[ch_r] && run_r[ch_r]) begin
          st_nxt = fp_r[ch_r];
          fp_nxt[ch_r] = 1'b0;
          cpos_nxt = padd;
          if (padd >= 0) begin
            if (padd > $signed({2'b00, per_r[ch_r]})) cpos_nxt = $signed({2'b00, per_r[ch_r]});
            state_nxt = acb_pkg::S_TMUL;
          end else begin
            wr_pos = 1'b1; pos_w = padd;
            if (fp_r[ch_r]) begin
              if (nres_r < 4'd8) begin
                ov_nxt = 1'b1; och_nxt = ch_r; ost_nxt = 1'b1;
                ocv_nxt = val_r[ch_r]; orun_nxt = 1'b1;
                nres_nxt = nres_r + 4'd1;
              end
            end
            state_nxt = acb_pkg::S_TFIN;
          end
        end else begin
          state_nxt = acb_pkg::S_TFIN;
        end
      end
      acb_pkg::S_TMUL: begin
        dreq.start = 1'b1;
        dreq.dividend = mulw[33:0];
        dreq.divisor = per_r[ch_r];
        state_nxt = acb_pkg::S_TDIV;
      end
      acb_pkg::S_TDIV: begin
        if (drsp.done) begin
          v = 17'(fs + 17'(drsp.quotient));
          wr_pos = 1'b1; pos_w = cpos_r;
          wr_val = 1'b1; val_w = val_r[ch_r];
          ovc_nxt = (v != val_r[ch_r]);
          if (ovc_nxt) val_w = v;
          if (cpos_r >= $signed({2'b00, per_r[ch_r]})) begin
            val_w = '0;
            if (rep_r[ch_r] == acb_pkg::FOREVER_CODE) again = 1'b1;
            else if (rep_r[ch_r] != 8'd0) rdec = rep_r[ch_r] - 8'd1;
            if (rdec != 8'd0) again = 1'b1;
            rep_w = rdec;
            if (again) begin
              wr_rel = 1'b1;
              pos_w = -$signed({2'b00, dly_r[ch_r]});
              if (swp_r[ch_r]) begin nf = ts; nt = fs; end
              if (nf < nt) val_w = nf - 17'sd1;
              else if (nf > nt) val_w = nf + 17'sd1;
              orl_nxt = 1'b1;
            end else begin
              run_nxt[ch_r] = 1'b0;
              ofn_nxt = 1'b1;
            end
          end
          if ((st_r || ovc_nxt || orl_nxt || ofn_nxt) && nres_r < 4'd8) begin
            ov_nxt = 1'b1; och_nxt = ch_r; ost_nxt = st_r;
            ocv_nxt = val_w; orun_nxt = run_nxt[ch_r];
            nres_nxt = nres_r + 4'd1;
          end else begin
            ovc_nxt = 1'b0; orl_nxt = 1'b0; ofn_nxt = 1'b0;
          end
          state_nxt = acb_pkg::S_TFIN;
        end
      end
      acb_pkg::S_TFIN: begin
        if (ch_r == 3'(N - 1)) begin
          state_nxt = acb_pkg::S_TEMPTY;
        end else begin
          ch_nxt = ch_r + 3'd1;
          state_nxt = acb_pkg::S_TLOAD;
        end
      end
      acb_pkg::S_TEMPTY: begin
        // out_last is flagged on the held final result below
        state_nxt = acb_pkg::S_IDLE;
      end
      default: state_nxt = acb_pkg::S_IDLE;
    endcase
  end

  // Tick results are held one slot so the last one can be tagged.
  logic hv_r;
  logic [1:0] hstat_r;
  logic [2:0] hch_r;
  logic signed [16:0] hcv_r;
  logic hst_r, hvc_r, hrl_r, hfn_r, hrun_r;
  logic tick_end;
  assign tick_end = (state_r == acb_pkg::S_TEMPTY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acb_pkg::S_IDLE;
      minp_r <= acb_pkg::MIN_PERIOD_RESET;
      used_r <= '0; run_r <= '0; fp_r <= '0;
      out_valid <= 1'b0; out_last <= 1'b0; hv_r <= 1'b0;
      nres_r <= '0; ch_r <= '0; st_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) minp_r <= cfg_min_period;
      used_r <= used_nxt; run_r <= run_nxt; fp_r <= fp_nxt;
      nres_r <= nres_nxt; ch_r <= ch_nxt; st_r <= st_nxt;
      out_valid <= (state_r == acb_pkg::S_CMD) || (ov_nxt && hv_r) || tick_end;
      out_last <= (state_r == acb_pkg::S_CMD) || tick_end;
      if (ov_nxt && state_r != acb_pkg::S_CMD) begin
        hv_r <= 1'b1;
      end else if (tick_end) begin
        hv_r <= 1'b0;
      end
    end
    if (state_r == acb_pkg::S_CMD) begin
      out_status <= ostat_nxt; out_channel_out <= och_nxt;
      out_current_value <= ocv_nxt; out_started <= 1'b0;
      out_value_changed <= 1'b0; out_reloaded <= 1'b0;
      out_finished <= 1'b0; out_is_running <= orun_nxt;
    end else if (ov_nxt || tick_end) begin
      out_status <= hv_r ? hstat_r : acb_pkg::ST_OK;
      out_channel_out <= hv_r ? hch_r : 3'd0;
      out_current_value <= hv_r ? hcv_r : 17'sd0;
      out_started <= hv_r & hst_r; out_value_changed <= hv_r & hvc_r;
      out_reloaded <= hv_r & hrl_r; out_finished <= hv_r & hfn_r;
      out_is_running <= hv_r & hrun_r;
    end
    if (ov_nxt && state_r != acb_pkg::S_CMD) begin
      hstat_r <= ostat_nxt; hch_r <= och_nxt; hcv_r <= ocv_nxt;
      hst_r <= ost_nxt; hvc_r <= ovc_nxt; hrl_r <= orl_nxt;
      hfn_r <= ofn_nxt; hrun_r <= orun_nxt;
    end
    if (state_r == acb_pkg::S_IDLE && start) begin
      op_r <= in_opcode; el_r <= in_elapsed_ticks; dl_r <= in_delay_ticks;
      pd_r <= in_period_ticks; rc_r <= in_repeat_count; pp_r <= in_ping_pong;
      sv_r <= in_start_value; ev_r <= in_end_value;
    end
    cpos_r <= cpos_nxt;
    if (wr_new) begin
      pos_r[free_idx] <= -$signed({2'b00, dl_r});
      dly_r[free_idx] <= dl_r;
      per_r[free_idx] <= (pd_r < mp) ? mp : pd_r;
      rep_r[free_idx] <= rc_r;
      swp_r[free_idx] <= pp_r;
      from_r[free_idx] <= nf;
      to_r[free_idx] <= nt;
      val_r[free_idx] <= ocv_nxt;
    end
    if (wr_pos) pos_r[ch_r] <= pos_w;
    if (wr_val) begin
      val_r[ch_r] <= val_w;
      rep_r[ch_r] <= rep_w;
    end
    if (wr_rel) begin
      from_r[ch_r] <= nf;
      to_r[ch_r] <= nt;
    end
  end

  assign busy = (state_r != acb_pkg::S_IDLE);
  assign cfg_ready = (state_r == acb_pkg::S_IDLE);

`ifndef SYNTHESIS
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid) else $error("last without valid");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && $past(!busy)) |-> !out_valid) else $error("result while idle");
  a_run_used: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r & ~used_r) == '0) else $error("running free channel");
`endif
endmodule
